>>> sv/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the min-tracking stack: transaction
// structs, status codes, controller states and default sizes.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int MTS_STACK_DEPTH = 64;
  localparam int MTS_DATA_WIDTH  = 32;

  localparam int OUT_WORD_W  = 32;
  localparam int OUT_COUNT_W = 7;

  localparam logic [OUT_WORD_W-1:0] WORD_ALL_ONES = '1;

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_POP_WAIT
  } state_t;

  typedef struct packed {
    mode_t                   mode;
    logic signed [31:0]      value;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_WORD_W-1:0] popped_value;
    logic signed [OUT_WORD_W-1:0] top_value;
    logic signed [OUT_WORD_W-1:0] min_value;
    logic [OUT_COUNT_W-1:0]       entry_count;
    logic                         is_empty;
    status_t                      status;
  } out_item_t;

endpackage

>>> sv/min_tracking_stack_core.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_core
// Bounded stack of signed words that reports its running minimum; each entry
// in one synchronous RAM holds its value and the minimum of it and below.
// ----------------------------------------------------------------------------
// A push, a rejected push or pop, or a pop that empties the stack strobes its
//   result in the cycle after start is taken.
// A pop that leaves entries behind enters ST_POP_WAIT: busy is high for one
//   cycle while the registered RAM read of the new top entry returns.
// Throughput: one transaction per cycle while busy is low.
// Reset clears the entry count and the controller; RAM contents are not
//   cleared. The result strobe lasts one cycle and cannot be held off.
module min_tracking_stack_core
  import mts_pkg::*;
#(
  parameter int STACK_DEPTH = MTS_STACK_DEPTH,
  parameter int DATA_WIDTH  = MTS_DATA_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int XW = DATA_WIDTH + OUT_WORD_W;
  localparam int KW = CW + OUT_COUNT_W;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] val;
    logic signed [DATA_WIDTH-1:0] min;
  } entry_t;

  // Entry RAM: one write port, one registered read port.
  entry_t           mem [STACK_DEPTH];
  entry_t           rd_data_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;

  state_t                       state_r, state_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic signed [DATA_WIDTH-1:0] top_val_r, top_val_nxt;
  logic signed [DATA_WIDTH-1:0] top_min_r, top_min_nxt;
  logic signed [DATA_WIDTH-1:0] pop_val_r, pop_val_nxt;
  logic                         out_valid_r, out_valid_nxt;
  out_item_t                    out_item_r, out_item_nxt;

  logic                         accept;
  logic                         is_full;
  logic [XW-1:0]                in_wide;
  logic signed [DATA_WIDTH-1:0] in_word;
  logic signed [DATA_WIDTH-1:0] push_min;
  logic [CW-1:0]                below_cnt;

  // Narrow or widen a stored word to the 32-bit result field (zero-filled).
  function automatic logic [OUT_WORD_W-1:0] to_out(input logic [DATA_WIDTH-1:0] w);
    logic [XW-1:0] t;
    t = {{OUT_WORD_W{1'b0}}, w};
    return t[OUT_WORD_W-1:0];
  endfunction

  function automatic out_item_t make_result(
    input logic [OUT_WORD_W-1:0] popped,
    input logic [DATA_WIDTH-1:0] top,
    input logic [DATA_WIDTH-1:0] mn,
    input logic [CW-1:0]         cnt,
    input status_t               st
  );
    out_item_t     r;
    logic [KW-1:0] k;
    k              = {{OUT_COUNT_W{1'b0}}, cnt};
    r.popped_value = popped;
    r.is_empty     = (cnt == '0);
    r.top_value    = r.is_empty ? WORD_ALL_ONES : to_out(top);
    r.min_value    = r.is_empty ? WORD_ALL_ONES : to_out(mn);
    r.entry_count  = k[OUT_COUNT_W-1:0];
    r.status       = st;
    return r;
  endfunction

  assign busy      = (state_r == ST_POP_WAIT);
  assign accept    = start && !busy;
  assign is_full   = (count_r == CW'(STACK_DEPTH));
  assign in_wide   = {{DATA_WIDTH{1'b0}}, in_item.value};
  assign in_word   = in_wide[DATA_WIDTH-1:0];
  assign below_cnt = count_r - CW'(2);

  // The first entry's minimum is its own value; otherwise compare with the
  // running minimum held by the current top entry.
  assign push_min  = ((count_r != '0) && (top_min_r < in_word)) ? top_min_r : in_word;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    top_val_nxt   = top_val_r;
    top_min_nxt   = top_min_r;
    pop_val_nxt   = pop_val_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_we        = 1'b0;
    mem_waddr     = count_r[AW-1:0];
    mem_wdata     = '{val: in_word, min: push_min};
    mem_re        = 1'b0;
    mem_raddr     = below_cnt[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          if (in_item.mode == MODE_PUSH) begin
            if (is_full) begin
              out_item_nxt = make_result(WORD_ALL_ONES, top_val_r, top_min_r,
                                         count_r, STAT_FULL);
            end else begin
              // Write the new entry and cache it as the top.
              mem_we       = 1'b1;
              top_val_nxt  = in_word;
              top_min_nxt  = push_min;
              count_nxt    = count_r + CW'(1);
              out_item_nxt = make_result(WORD_ALL_ONES, in_word, push_min,
                                         count_nxt, STAT_OK);
            end
          end else begin
            if (count_r == '0) begin
              out_item_nxt = make_result(WORD_ALL_ONES, top_val_r, top_min_r,
                                         count_r, STAT_EMPTY);
            end else begin
              count_nxt = count_r - CW'(1);
              if (count_r == CW'(1)) begin
                out_item_nxt = make_result(to_out(top_val_r), top_val_r, top_min_r,
                                           count_nxt, STAT_OK);
              end else begin
                // Fetch the entry below; hold the result until it returns.
                out_valid_nxt = 1'b0;
                mem_re        = 1'b1;
                pop_val_nxt   = top_val_r;
                state_nxt     = ST_POP_WAIT;
              end
            end
          end
        end
      end
      ST_POP_WAIT: begin
        top_val_nxt   = rd_data_r.val;
        top_min_nxt   = rd_data_r.min;
        out_valid_nxt = 1'b1;
        out_item_nxt  = make_result(to_out(pop_val_r), rd_data_r.val, rd_data_r.min,
                                    count_r, STAT_OK);
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Entry RAM.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Cached top entry and result payload.
  always_ff @(posedge clk) begin
    top_val_r  <= top_val_nxt;
    top_min_r  <= top_min_nxt;
    pop_val_r  <= pop_val_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
